>>> sv/bbr_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and codes of the 3x3 box blur
// no dependencies
package bbr_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 4096;
	localparam int CHANNEL_BITS = 16;
	localparam int NUM_CH       = 4;

	// frame position counters
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
	localparam int EFF_W_W = $clog2(MAX_WIDTH + 1);
	localparam int EFF_H_W = $clog2(MAX_HEIGHT + 1);

	// configuration port
	localparam int CFG_WIDTH_W  = 12;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	// opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// arithmetic widths
	localparam int COLSUM_W  = CHANNEL_BITS + 2;
	localparam int SUM_W     = CHANNEL_BITS + 4;
	localparam int DIV_SHIFT = SUM_W + 3;
	localparam int RECIP_W   = DIV_SHIFT - 1;
	localparam int PROD_W    = SUM_W + RECIP_W;

	// reciprocals rounded up, exact for any dividend below 2**SUM_W
	localparam logic [RECIP_W-1:0] RECIP_4 =
		RECIP_W'((64'd1 << DIV_SHIFT) / 64'd4);
	localparam logic [RECIP_W-1:0] RECIP_6 =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd5) / 64'd6);
	localparam logic [RECIP_W-1:0] RECIP_9 =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);

	// command queue
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] pix_t;

	// divisor class: corner, edge, interior
	typedef logic [1:0] div_t;
	localparam div_t DIV4 = 2'd0;
	localparam div_t DIV6 = 2'd1;
	localparam div_t DIV9 = 2'd2;

	typedef struct packed {
		logic lft;
		logic rgt;
		logic top;
		logic bot;
	} mask_t;

	typedef struct packed {
		pix_t             pix;
		logic [COL_W-1:0] col;
		logic             emit;
		mask_t            mask;
		div_t             div;
		logic             frame_end;
	} cmd_t;

	typedef struct packed {
		pix_t pix;
		logic frame_end;
	} res_t;

endpackage

>>> sv/bbr_cmdq.sv
`timescale 1ns / 1ps
// short command queue between the front and the back of the box blur
// depends on bbr_pkg
module bbr_cmdq import bbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  wr_ok;
	logic                  rd_ok;

	assign full    = count_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign empty   = count_q == '0;
	assign wr_ok   = wr_en && !full;
	assign rd_ok   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
		return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_ok) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_ok && !rd_ok) begin
				count_q <= count_q + 1'b1;
			end else if (rd_ok && !wr_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_fill_counts: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ok && !rd_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("command queue fill count did not follow a lone write");

endmodule

>>> sv/bbr_front.sv
`timescale 1ns / 1ps
// front of the box blur: configuration, frame position and classification of items
// depends on bbr_pkg
module bbr_front import bbr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   push,
	input  logic                   opcode,
	input  pix_t                   pix,
	input  logic                   cmdq_full,
	output logic                   cmd_push,
	output cmd_t                   cmd
);

	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;
	logic [ROW_W-1:0]        in_row_q;
	logic [COL_W-1:0]        in_col_q;

	logic [EFF_W_W-1:0] eff_w;
	logic [EFF_H_W-1:0] eff_h;
	logic [COL_W-1:0]   w_last;
	logic [ROW_W-1:0]   h_last;
	logic               draining;
	logic               act;
	logic               emit_mid;
	logic               emit_wrap;
	logic               emit;
	logic [ROW_W-1:0]   orow;
	logic [COL_W-1:0]   ocol;
	mask_t              mask;
	logic               frame_end_c;
	logic               col_wrap;

	always_comb begin
		eff_w = EFF_W_W'(width_q);
		if (width_q < CFG_WIDTH_W'(2)) begin
			eff_w = EFF_W_W'(2);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = EFF_W_W'(MAX_WIDTH);
		end
		eff_h = EFF_H_W'(height_q);
		if (height_q < CFG_HEIGHT_W'(2)) begin
			eff_h = EFF_H_W'(2);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			eff_h = EFF_H_W'(MAX_HEIGHT);
		end
	end

	assign w_last   = COL_W'(eff_w - EFF_W_W'(1));
	assign h_last   = ROW_W'(eff_h - EFF_H_W'(1));
	assign draining = in_row_q >= ROW_W'(eff_h);

	// a flush before the drain phase is taken and dropped
	assign act = push && !cmdq_full && !(opcode == OP_FLUSH && !draining);

	assign emit_mid  = (in_row_q != '0) && (in_col_q != '0);
	assign emit_wrap = (in_row_q >= ROW_W'(2)) && (in_col_q == '0);
	assign emit      = emit_mid || emit_wrap;

	assign orow = emit_mid ? in_row_q - ROW_W'(1) : in_row_q - ROW_W'(2);
	assign ocol = emit_mid ? in_col_q - COL_W'(1) : w_last;

	assign mask.lft = ocol != '0;
	assign mask.rgt = ocol < w_last;
	assign mask.top = orow != '0;
	assign mask.bot = orow < h_last;

	assign frame_end_c = emit && (orow >= h_last) && (ocol >= w_last);
	assign col_wrap    = (EFF_W_W'(in_col_q) + EFF_W_W'(1)) >= eff_w;

	always_comb begin
		cmd.pix       = draining ? '0 : pix;
		cmd.col       = in_col_q;
		cmd.emit      = emit;
		cmd.mask      = mask;
		cmd.frame_end = frame_end_c;
		if (mask.lft && mask.rgt && mask.top && mask.bot) begin
			cmd.div = DIV9;
		end else if ((mask.lft && mask.rgt) || (mask.top && mask.bot)) begin
			cmd.div = DIV6;
		end else begin
			cmd.div = DIV4;
		end
	end

	assign cmd_push = act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (act) begin
			priority if (frame_end_c) begin
				in_row_q <= '0;
				in_col_q <= '0;
			end else if (col_wrap) begin
				in_row_q <= in_row_q + 1'b1;
				in_col_q <= '0;
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
		end
	end

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.frame_end |=> in_row_q == '0 && in_col_q == '0)
		else $error("position did not return to origin after frame end");

	a_early_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push && !cmdq_full && opcode == OP_FLUSH && !draining
		|=> $stable(in_row_q) && $stable(in_col_q))
		else $error("flush before drain moved the position");

	a_end_is_corner: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.frame_end |-> cmd.div == DIV4)
		else $error("last pixel of frame not classed as corner");

endmodule

>>> sv/bbr_back.sv
`timescale 1ns / 1ps
// back of the box blur: line store, window, masked sums and divide by 4, 6 or 9
// depends on bbr_pkg
module bbr_back import bbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	output logic res_valid,
	output res_t res,
	input  logic res_take
);

	typedef logic [NUM_CH-1:0][COLSUM_W-1:0] csum_t;
	typedef logic [NUM_CH-1:0][SUM_W-1:0]    sum_t;
	typedef logic [NUM_CH-1:0][PROD_W-1:0]   prod_t;

	typedef struct packed {
		pix_t older;
		pix_t newer;
	} line_t;

	// two previous rows per column, one word per column
	line_t line_mem [MAX_WIDTH];

	logic  valid_s1;
	cmd_t  cmd_s1;
	line_t line_s1;
	pix_t  win_q [6];

	logic  valid_s2;
	csum_t sum_l_s2;
	csum_t sum_m_s2;
	csum_t sum_r_s2;
	div_t  div_s2;
	logic  frame_s2;

	logic               valid_s3;
	sum_t               x_s3;
	logic [RECIP_W-1:0] recip_s3;
	logic               frame_s3;

	logic  valid_s4;
	prod_t prod_s4;
	logic  frame_s4;

	logic res_valid_q;
	res_t res_q;

	logic rdy_out;
	logic rdy_s4;
	logic rdy_s3;
	logic rdy_s2;
	logic rdy_s1;
	logic adv_s1;

	function automatic csum_t col_sum(input pix_t t, input pix_t m, input pix_t b,
		input logic use_t, input logic use_b, input logic use_col);
		csum_t s;
		for (int k = 0; k < NUM_CH; k++) begin
			s[k] = COLSUM_W'(m[k])
				+ (use_t ? COLSUM_W'(t[k]) : '0)
				+ (use_b ? COLSUM_W'(b[k]) : '0);
			if (!use_col) begin
				s[k] = '0;
			end
		end
		return s;
	endfunction

	function automatic logic [SUM_W-1:0] round_of(input div_t d);
		logic [SUM_W-1:0] r;
		unique case (d)
			DIV4:    r = SUM_W'(2);
			DIV6:    r = SUM_W'(3);
			DIV9:    r = SUM_W'(4);
			default: r = SUM_W'(2);
		endcase
		return r;
	endfunction

	function automatic logic [RECIP_W-1:0] recip_of(input div_t d);
		logic [RECIP_W-1:0] r;
		unique case (d)
			DIV4:    r = RECIP_4;
			DIV6:    r = RECIP_6;
			DIV9:    r = RECIP_9;
			default: r = RECIP_4;
		endcase
		return r;
	endfunction

	// elastic chain, items without a result retire from stage 1
	assign rdy_out  = !res_valid_q || res_take;
	assign rdy_s4   = !valid_s4 || rdy_out;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign adv_s1   = valid_s1 && (rdy_s2 || !cmd_s1.emit);
	assign rdy_s1   = !valid_s1 || adv_s1;
	assign cmd_take = cmd_valid && rdy_s1;

	// stage 1: line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1  <= cmd;
			line_s1 <= line_mem[cmd.col];
		end
	end

	// write back once the read word is known; the only same-column
	// neighbors are a frame's last item and the next frame's first,
	// whose stale words land only on cells outside the frame
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			line_mem[cmd_s1.col] <= line_t'{older: line_s1.newer, newer: cmd_s1.pix};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= line_s1.older;
			win_q[4] <= line_s1.newer;
			win_q[5] <= cmd_s1.pix;
		end
	end

	// stage 2: masked column sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= adv_s1 && cmd_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && cmd_s1.emit) begin
			sum_l_s2 <= col_sum(win_q[0], win_q[1], win_q[2],
				cmd_s1.mask.top, cmd_s1.mask.bot, cmd_s1.mask.lft);
			sum_m_s2 <= col_sum(win_q[3], win_q[4], win_q[5],
				cmd_s1.mask.top, cmd_s1.mask.bot, 1'b1);
			sum_r_s2 <= col_sum(line_s1.older, line_s1.newer, cmd_s1.pix,
				cmd_s1.mask.top, cmd_s1.mask.bot, cmd_s1.mask.rgt);
			div_s2   <= cmd_s1.div;
			frame_s2 <= cmd_s1.frame_end;
		end
	end

	// stage 3: window total plus half divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && rdy_s3) begin
			for (int k = 0; k < NUM_CH; k++) begin
				x_s3[k] <= SUM_W'(sum_l_s2[k]) + SUM_W'(sum_m_s2[k])
					+ SUM_W'(sum_r_s2[k]) + round_of(div_s2);
			end
			recip_s3 <= recip_of(div_s2);
			frame_s3 <= frame_s2;
		end
	end

	// stage 4: multiply by reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && rdy_s4) begin
			for (int k = 0; k < NUM_CH; k++) begin
				prod_s4[k] <= PROD_W'(x_s3[k]) * PROD_W'(recip_s3);
			end
			frame_s4 <= frame_s3;
		end
	end

	// output register: quotient is the product shifted down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rdy_out) begin
			res_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && rdy_out) begin
			for (int k = 0; k < NUM_CH; k++) begin
				res_q.pix[k] <= prod_s4[k][DIV_SHIFT +: CHANNEL_BITS];
			end
			res_q.frame_end <= frame_s4;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> sv/box_blur_3x3_edge_renorm_top.sv
`timescale 1ns / 1ps
// top level of the streaming 3x3 box blur with edge renormalization
// depends on bbr_pkg, bbr_front, bbr_cmdq, bbr_back

// RGBA pixels of one frame enter in raster order through a queue-style port
// (push/full) and each result is the per-channel 3x3 mean of a pixel's
// neighborhood, leaving in raster order through a second queue-style port
// (empty/pop). Interior pixels average nine cells, edge pixels six and corner
// pixels four, each sum rounded to nearest with halves going up. Results lag
// the input by image_width+1 items; after the last pixel, image_width+1 flush
// items (opcode 1) drain the rest, and the last result of the frame carries
// frame_end. A flush sent while pixels are still expected is taken and
// dropped; a pixel sent while draining counts as a flush. image_width and
// image_height are clamped to [2, 2048] and [2, 4096]. The user must write
// them through the cfg port only while the block is idle; the block does not
// enforce this. The block takes one item per clock sustained while full is
// low: the front classifies each item in the cycle of its transfer, the two-row
// line store is one 2048 x 128-bit RAM read and written once per item, and the
// divide is one multiply by a reciprocal per channel. There is no clearing pass
// after reset; line store words never written only reach cells that lie
// outside the frame.
module box_blur_3x3_edge_renorm_top import bbr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration writes
	input  logic                    cfg_write,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  logic                    push,
	output logic                    full,
	input  logic                    opcode,
	input  logic [CHANNEL_BITS-1:0] red_in,
	input  logic [CHANNEL_BITS-1:0] green_in,
	input  logic [CHANNEL_BITS-1:0] blue_in,
	input  logic [CHANNEL_BITS-1:0] alpha_in,
	// results
	output logic                    empty,
	input  logic                    pop,
	output logic [CHANNEL_BITS-1:0] red_out,
	output logic [CHANNEL_BITS-1:0] green_out,
	output logic [CHANNEL_BITS-1:0] blue_out,
	output logic [CHANNEL_BITS-1:0] alpha_out,
	output logic                    frame_end
);

	pix_t pix_in;
	cmd_t front_cmd;
	logic front_push;
	logic cmdq_full;
	cmd_t back_cmd;
	logic cmdq_empty;
	logic back_take;
	logic res_valid;
	res_t res;

	// channel order inside a pixel word: red, green, blue, alpha
	assign pix_in[0] = red_in;
	assign pix_in[1] = green_in;
	assign pix_in[2] = blue_in;
	assign pix_in[3] = alpha_in;

	// front: config, position counters, flush handling and masks
	bbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.opcode    (opcode),
		.pix       (pix_in),
		.cmdq_full (cmdq_full),
		.cmd_push  (front_push),
		.cmd       (front_cmd)
	);

	// the input side stalls only when the command queue is full
	assign full = cmdq_full;

	// queue decouples the input transfer from the line store pipeline
	bbr_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_cmd),
		.full    (cmdq_full),
		.rd_en   (back_take),
		.rd_data (back_cmd),
		.empty   (cmdq_empty)
	);

	// back: line store, window, sums, reciprocal multiply, output register
	bbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmdq_empty),
		.cmd       (back_cmd),
		.cmd_take  (back_take),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (pop)
	);

	// oldest result sits on the ports while empty is low
	assign empty     = !res_valid;
	assign red_out   = res.pix[0];
	assign green_out = res.pix[1];
	assign blue_out  = res.pix[2];
	assign alpha_out = res.pix[3];
	assign frame_end = res.frame_end;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the streaming 3x3 box blur with edge renormalization
// depends on bbr_pkg and box_blur_3x3_edge_renorm_top; stand-alone, no files read

module testbench;
	import bbr_pkg::*;

	// run shape
	localparam int unsigned RANDOM_ITEMS  = 1350;
	localparam int unsigned SETTLE_CYCLES = 20;     // quiet time after the last owed result
	localparam int unsigned TAIL_CYCLES   = 30;
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	localparam int unsigned LONG_HOLD     = 500;    // receiver hold-off that backs up the block
	localparam int unsigned HOLD_FIRST    = 300;
	localparam int unsigned HOLD_SECOND   = 1000;

	// one entry of the sender's work list
	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_WRITE,
		STEP_SETTLE
	} step_kind_t;

	typedef struct packed {
		step_kind_t              kind;
		logic                    op;
		pix_t                    px;     // channel 0 red ... channel 3 alpha
		logic [CFG_INDEX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0]   val;
	} stim_step_t;

	// one predicted output pixel
	typedef struct packed {
		pix_t px;
		logic last;
	} blur_px_t;

	// dut signals, all inputs known from time zero
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    push = 1'b0;
	logic                    full;
	logic                    opcode = OP_PIXEL;
	logic [CHANNEL_BITS-1:0] red_in = '0;
	logic [CHANNEL_BITS-1:0] green_in = '0;
	logic [CHANNEL_BITS-1:0] blue_in = '0;
	logic [CHANNEL_BITS-1:0] alpha_in = '0;
	logic                    empty;
	logic                    pop = 1'b0;
	logic [CHANNEL_BITS-1:0] red_out;
	logic [CHANNEL_BITS-1:0] green_out;
	logic [CHANNEL_BITS-1:0] blue_out;
	logic [CHANNEL_BITS-1:0] alpha_out;
	logic                    frame_end;

	box_blur_3x3_edge_renorm_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.empty     (empty),
		.pop       (pop),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out),
		.frame_end (frame_end)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// blur predictor: own copy of the line stores, window and counters
	// ------------------------------------------------------------------
	logic [CFG_WIDTH_W-1:0]  reg_width  = WIDTH_RESET;
	logic [CFG_HEIGHT_W-1:0] reg_height = HEIGHT_RESET;
	pix_t                    line_older [MAX_WIDTH];
	pix_t                    line_newer [MAX_WIDTH];
	pix_t                    win_cols [6];      // left column then middle column, top to bottom
	int unsigned             in_col = 0;
	int unsigned             in_row = 0;
	blur_px_t                expected_px [$];   // blurred pixels still owed by the block

	// run statistics
	int unsigned errors = 0;
	int unsigned flushes_dropped = 0;
	int unsigned results_seen = 0;
	int unsigned frames_seen = 0;
	int unsigned transfers_in = 0;
	int unsigned widest = 0;
	int unsigned tallest = 0;
	int unsigned cycles = 0;

	initial begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			line_older[i] = '0;
			line_newer[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			win_cols[i] = '0;
	end

	// one accepted item: shift the window, update the line stores and
	// queue the blurred pixel it releases, if any
	function automatic void blur_predict(input logic op, input pix_t din);
		int unsigned w, h, ic, ir, orow, ocol, n, dx, dy, k;
		int unsigned acc [NUM_CH];
		logic        drain, emit, at_end;
		pix_t        p;
		pix_t        nb [3][3];   // [column left..right][row top..bottom]
		blur_px_t    res;
		w = (reg_width < 2) ? 2 : (reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width;
		h = (reg_height < 2) ? 2 : (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
		drain = (in_row >= h);
		// flush while pixels are still owed: taken and dropped
		if (op == OP_FLUSH && !drain) begin
			flushes_dropped++;
			return;
		end
		ic = (in_col >= MAX_WIDTH) ? 0 : in_col;
		ir = in_row;
		// pixel data sent while draining is dropped
		p = drain ? '0 : din;
		for (k = 0; k < 3; k++) begin
			nb[0][k] = win_cols[k];
			nb[1][k] = win_cols[3 + k];
		end
		nb[2][0] = line_older[ic];
		nb[2][1] = line_newer[ic];
		nb[2][2] = p;

		emit = 1'b0;
		orow = 0;
		ocol = 0;
		if (ir >= 1 && ic >= 1) begin
			orow = ir - 1;
			ocol = ic - 1;
			emit = 1'b1;
		end else if (ir >= 2 && ic == 0) begin
			// last column of the row before, released by the wrap
			orow = ir - 2;
			ocol = w - 1;
			emit = 1'b1;
		end
		at_end = emit && (orow >= h - 1) && (ocol >= w - 1);

		if (emit) begin
			n = 0;
			acc = '{default: 0};
			for (dx = 0; dx < 3; dx++) begin
				if ((dx == 0 && ocol < 1) || (dx == 2 && ocol + 1 >= w))
					continue;
				for (dy = 0; dy < 3; dy++) begin
					if ((dy == 0 && orow < 1) || (dy == 2 && orow + 1 >= h))
						continue;
					n++;
					for (k = 0; k < NUM_CH; k++)
						acc[k] += nb[dx][dy][k];
				end
			end
			// round to nearest, halves up; n is 4, 6 or 9
			for (k = 0; k < NUM_CH; k++)
				res.px[k] = CHANNEL_BITS'((acc[k] + n / 2) / n);
			res.last = at_end;
			expected_px.push_back(res);
			if (w > widest) widest = w;
			if (h > tallest) tallest = h;
		end

		line_older[ic] = line_newer[ic];
		line_newer[ic] = p;
		for (k = 0; k < 3; k++) begin
			win_cols[k]     = nb[1][k];
			win_cols[3 + k] = nb[2][k];
		end

		if (at_end) begin
			in_col = 0;
			in_row = 0;
		end else if (ic + 1 >= w) begin
			in_col = 0;
			in_row = ir + 1;
		end else begin
			in_col = ic + 1;
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus generation; gen_w and gen_h follow the clamped frame size
	// ------------------------------------------------------------------
	stim_step_t  stim_q [$];
	int unsigned gen_w = 640;
	int unsigned gen_h = 480;
	int unsigned work_items = 0;   // items that do real work, dropped flushes not counted

	function automatic pix_t rgba(input int unsigned r, input int unsigned g,
			input int unsigned b, input int unsigned a);
		pix_t p;
		p[0] = CHANNEL_BITS'(r);
		p[1] = CHANNEL_BITS'(g);
		p[2] = CHANNEL_BITS'(b);
		p[3] = CHANNEL_BITS'(a);
		return p;
	endfunction

	function automatic pix_t rand_pix();
		pix_t p;
		int   k;
		for (k = 0; k < NUM_CH; k++)
			case ($urandom_range(0, 7))
				0:       p[k] = '0;
				1:       p[k] = '1;
				2:       p[k] = CHANNEL_BITS'($urandom_range(0, 15));
				default: p[k] = CHANNEL_BITS'($urandom);
			endcase
		return p;
	endfunction

	function automatic void add_item(input logic op, input pix_t px);
		stim_step_t s;
		s      = '0;
		s.kind = STEP_ITEM;
		s.op   = op;
		s.px   = px;
		stim_q.push_back(s);
	endfunction

	function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
		stim_step_t  s;
		int unsigned v;
		s      = '0;
		s.kind = STEP_WRITE;
		s.idx  = idx;
		s.val  = CFG_DATA_W'(val);
		stim_q.push_back(s);
		if (idx == REG_IMAGE_WIDTH) begin
			v = val & 32'hFFF;
			gen_w = (v < 2) ? 2 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
		end else begin
			v = val & 32'h1FFF;
			gen_h = (v < 2) ? 2 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
		end
	endfunction

	// sender waits for every owed result, then a settle pause
	function automatic void add_settle();
		stim_step_t s;
		s      = '0;
		s.kind = STEP_SETTLE;
		stim_q.push_back(s);
	endfunction

	// full rows of pixels; noise puts stray flushes in front of some pixels
	function automatic void add_rows(input int unsigned rows, input int unsigned noise);
		for (int unsigned i = 0; i < rows * gen_w; i++) begin
			if ($urandom_range(0, 99) < noise)
				add_item(OP_FLUSH, rand_pix());
			add_item(OP_PIXEL, rand_pix());
		end
		work_items += rows * gen_w;
	endfunction

	// width+1 drain items; with noise some are pixels and a stray flush may follow the end
	function automatic void add_drain(input int unsigned noise);
		for (int unsigned i = 0; i <= gen_w; i++)
			add_item(($urandom_range(0, 99) < noise) ? OP_PIXEL : OP_FLUSH, rand_pix());
		if ($urandom_range(0, 99) < noise)
			add_item(OP_FLUSH, rand_pix());
		work_items += gen_w + 1;
	endfunction

	function automatic int unsigned idle_draw(inout logic burst);
		if ($urandom_range(0, 31) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 14);
	endfunction

	// ------------------------------------------------------------------
	// sender: works through stim_q, one transfer per accepted item
	// ------------------------------------------------------------------
	stim_step_t  cur_step;
	logic        step_busy = 1'b0;
	int unsigned step_gap = 0;
	logic        drv_burst = 1'b0;
	logic        push_nx;
	logic        write_nx;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push      <= 1'b0;
			cfg_write <= 1'b0;
			step_busy = 1'b0;
			step_gap  = 0;
		end else begin
			push_nx  = push;
			write_nx = 1'b0;
			if (push && !full) begin
				// input transfer of the item on the ports
				blur_predict(cur_step.op, cur_step.px);
				transfers_in++;
				push_nx   = 1'b0;
				step_busy = 1'b0;
			end
			if (!push_nx) begin
				if (!step_busy && stim_q.size() != 0) begin
					cur_step  = stim_q.pop_front();
					step_busy = 1'b1;
					case (cur_step.kind)
						STEP_ITEM:   step_gap = idle_draw(drv_burst);
						STEP_SETTLE: step_gap = SETTLE_CYCLES;
						default:     step_gap = 0;
					endcase
				end
				if (step_busy) begin
					case (cur_step.kind)
						STEP_ITEM: begin
							if (step_gap == 0) begin
								// a zero gap keeps push high straight into the next item
								push_nx   = 1'b1;
								opcode    <= cur_step.op;
								red_in    <= cur_step.px[0];
								green_in  <= cur_step.px[1];
								blue_in   <= cur_step.px[2];
								alpha_in  <= cur_step.px[3];
							end else begin
								step_gap--;
							end
						end
						STEP_WRITE: begin
							write_nx  = 1'b1;
							cfg_index <= cur_step.idx;
							cfg_data  <= cur_step.val;
							if (cur_step.idx == REG_IMAGE_WIDTH)
								reg_width = cur_step.val[CFG_WIDTH_W-1:0];
							else
								reg_height = cur_step.val;
							step_busy = 1'b0;
						end
						default: begin
							// pause: nothing owed, then let the pipe go quiet
							if (expected_px.size() == 0) begin
								if (step_gap == 0)
									step_busy = 1'b0;
								else
									step_gap--;
							end
						end
					endcase
				end
			end
			push      <= push_nx;
			cfg_write <= write_nx;
		end
	end

	// ------------------------------------------------------------------
	// receiver: pops with random stalls, checks each result transfer
	// ------------------------------------------------------------------
	string       chan_name [NUM_CH] = '{"red_out", "green_out", "blue_out", "alpha_out"};
	blur_px_t    want_px;
	pix_t        got_px;
	int unsigned pop_gap = 0;
	logic        mon_burst = 1'b0;
	logic        pop_nx;

	function automatic void check_field(input string name, input logic [CHANNEL_BITS-1:0] want,
			input logic [CHANNEL_BITS-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop     <= 1'b0;
			pop_gap = 0;
		end else begin
			pop_nx = pop;
			if (pop && !empty) begin
				got_px = {alpha_out, blue_out, green_out, red_out};
				if (expected_px.size() == 0) begin
					errors++;
					$display("%0t: result expected none, got rgba %h frame_end %b",
						$time, got_px, frame_end);
				end else begin
					want_px = expected_px.pop_front();
					for (int k = 0; k < NUM_CH; k++)
						check_field(chan_name[k], want_px.px[k], got_px[k]);
					check_field("frame_end", want_px.last, frame_end);
					if (want_px.last)
						frames_seen++;
				end
				results_seen++;
				// twice in the run hold off long enough for the block to back up
				if (results_seen == HOLD_FIRST || results_seen == HOLD_SECOND)
					pop_gap = LONG_HOLD;
				else
					pop_gap = idle_draw(mon_burst);
				pop_nx = (pop_gap == 0);
			end else if (!pop) begin
				if (pop_gap != 0)
					pop_gap--;
				pop_nx = (pop_gap == 0);
			end
			pop <= pop_nx;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items queued, %0d results owed",
				cycles, stim_q.size(), expected_px.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus plan, reset and end of run
	// ------------------------------------------------------------------
	int unsigned nframes, noise, k_rows, sel;

	initial begin
		// corners only: register values below range clamp to a 2x2 frame
		add_write(REG_IMAGE_WIDTH, 1);
		add_write(REG_IMAGE_HEIGHT, 0);
		add_item(OP_PIXEL, rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		add_item(OP_PIXEL, rgba(0, 0, 0, 0));
		add_item(OP_FLUSH, rgba(16'hFFFF, 0, 16'hFFFF, 0));   // early flush, dropped
		add_item(OP_PIXEL, rgba(1, 2, 3, 0));
		add_item(OP_PIXEL, rgba(16'hFFFF, 0, 1, 16'h8000));
		add_item(OP_FLUSH, rgba(0, 0, 0, 0));
		add_item(OP_PIXEL, rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)); // data dropped in drain
		add_item(OP_FLUSH, rgba(0, 0, 0, 0));
		add_item(OP_FLUSH, rgba(0, 0, 0, 0));                 // past frame end, dropped

		// 3x3: corners, edges and the one interior pixel; alpha hits the half-up cases
		add_settle();
		add_write(REG_IMAGE_WIDTH, 3);
		add_write(REG_IMAGE_HEIGHT, 3);
		for (int unsigned i = 0; i < 9; i++)
			add_item(OP_PIXEL, rgba(16'hFFFF, 0, i, (i == 0) ? 3 : 0));
		add_drain(0);

		// height raised while a frame is open
		add_settle();
		add_write(REG_IMAGE_WIDTH, 4);
		add_write(REG_IMAGE_HEIGHT, 2);
		add_rows(1, 0);
		add_settle();
		add_write(REG_IMAGE_HEIGHT, 3);
		add_rows(2, 0);
		add_drain(0);

		// width cut from 6 to 3 with the input at column 3 of row 2
		add_settle();
		add_write(REG_IMAGE_WIDTH, 6);
		add_write(REG_IMAGE_HEIGHT, 4);
		add_rows(2, 0);
		for (int i = 0; i < 3; i++)
			add_item(OP_PIXEL, rand_pix());
		add_settle();
		add_write(REG_IMAGE_WIDTH, 3);
		for (int i = 0; i < 4; i++)
			add_item(OP_PIXEL, rand_pix());
		add_drain(0);
		add_item(OP_FLUSH, rand_pix());

		// random phases of mostly small frames
		work_items = 0;
		while (work_items < RANDOM_ITEMS) begin
			add_settle();
			sel = $urandom_range(0, 3);
			if (sel != 1) begin
				case ($urandom_range(0, 15))
					0:       add_write(REG_IMAGE_WIDTH, $urandom_range(0, 1));
					1:       add_write(REG_IMAGE_WIDTH, $urandom_range(13, 40));
					default: add_write(REG_IMAGE_WIDTH, $urandom_range(2, 10));
				endcase
			end
			if (sel != 2) begin
				case ($urandom_range(0, 15))
					0:       add_write(REG_IMAGE_HEIGHT, $urandom_range(0, 1));
					1:       add_write(REG_IMAGE_HEIGHT, $urandom_range(9, 16));
					default: add_write(REG_IMAGE_HEIGHT, $urandom_range(2, 8));
				endcase
			end
			nframes = $urandom_range(1, 3);
			noise   = ($urandom_range(0, 3) == 0) ? 10 : 0;
			if ($urandom_range(0, 9) == 0) begin
				// height moved mid-frame; a clean drain keeps the frame bookkeeping exact
				k_rows = $urandom_range(1, gen_h - 1);
				add_rows(k_rows, noise);
				add_settle();
				add_write(REG_IMAGE_HEIGHT, $urandom_range(2, 10));
				if (k_rows < gen_h)
					add_rows(gen_h - k_rows, noise);
				add_drain(0);
				add_item(OP_FLUSH, rand_pix());
				nframes--;
			end
			for (int unsigned f = 0; f < nframes; f++) begin
				add_rows(gen_h, noise);
				add_drain(noise);
			end
		end

		// largest sizes, reached through the clamp with every register bit set;
		// the frame is narrowed or shortened part way so the run stays short
		add_settle();
		add_write(REG_IMAGE_WIDTH, 12'hFFF);
		add_write(REG_IMAGE_HEIGHT, 2);
		for (int i = 0; i < 40; i++)
			add_item(OP_PIXEL, rand_pix());
		add_settle();
		add_write(REG_IMAGE_WIDTH, 5);
		for (int i = 0; i < 6; i++)
			add_item(OP_PIXEL, rand_pix());
		add_drain(0);
		add_settle();
		add_write(REG_IMAGE_WIDTH, 0);
		add_write(REG_IMAGE_HEIGHT, 13'h1FFF);
		add_rows(5, 0);
		add_settle();
		add_write(REG_IMAGE_HEIGHT, 6);
		add_rows(1, 0);
		add_drain(0);

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (stim_q.size() != 0 || step_busy || push)
			@(posedge clk);
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d input transfers (%0d early flushes dropped), %0d blurred pixels checked",
			transfers_in, flushes_dropped, results_seen);
		$display("%0d frames completed, sizes up to %0d wide and %0d tall",
			frames_seen, widest, tallest);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
